>>> sv/spcc_pkg.sv
// package: opcodes, host operations, stop causes and widths for the processor core
`timescale 1ns / 1ps
package spcc_pkg;
  localparam int unsigned MEM_WORDS_DEF = 4096;
  localparam int unsigned NUM_REGS_DEF  = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned HADDR_W       = 12;
  localparam int unsigned LIMIT_W       = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

  localparam logic [2:0] HOP_WRITE = 3'd0;
  localparam logic [2:0] HOP_READ  = 3'd1;
  localparam logic [2:0] HOP_START = 3'd2;
  localparam logic [2:0] HOP_STEP  = 3'd3;
  localparam logic [2:0] HOP_REG   = 3'd4;

  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_LOAD  = 8'd1;
  localparam logic [7:0] OP_ST    = 8'd2;
  localparam logic [7:0] OP_ADD   = 8'd3;
  localparam logic [7:0] OP_SUB   = 8'd4;
  localparam logic [7:0] OP_MUL   = 8'd5;
  localparam logic [7:0] OP_DIV   = 8'd6;
  localparam logic [7:0] OP_JMP   = 8'd7;
  localparam logic [7:0] OP_JEQ   = 8'd8;
  localparam logic [7:0] OP_JNE   = 8'd9;
  localparam logic [7:0] OP_HALT  = 8'd10;

  localparam logic [2:0] CAUSE_NONE  = 3'd0;
  localparam logic [2:0] CAUSE_HALT  = 3'd1;
  localparam logic [2:0] CAUSE_DIV0  = 3'd2;
  localparam logic [2:0] CAUSE_BADOP = 3'd3;
  localparam logic [2:0] CAUSE_LIMIT = 3'd4;

  // request from the sequencer to the shared alu
  typedef struct packed {
    logic       start;
    logic [1:0] fn;   // 0 add, 1 sub, 2 mul, 3 div
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_stat_t;

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;
endpackage

>>> sv/spcc_if.sv
// valid/ready channel interfaces for host words and result words
`timescale 1ns / 1ps
interface spcc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [11:0] host_address;
  logic [31:0] write_data;
  modport source (output valid, operation, host_address, write_data, input ready);
  modport sink (input valid, operation, host_address, write_data, output ready);
endinterface

interface spcc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] pc_value;
  logic [31:0] fetched_word;
  logic        is_running;
  logic [2:0]  stop_cause;
  logic        bounds_error;
  modport source (output valid, read_data, pc_value, fetched_word, is_running,
                  stop_cause, bounds_error, input ready);
  modport sink (input valid, read_data, pc_value, fetched_word, is_running,
                stop_cause, bounds_error, output ready);
endinterface

>>> sv/spcc_alu.sv
// shared arithmetic unit: add, sub, mul and radix-2 divide
`timescale 1ns / 1ps
module spcc_alu
  import spcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_req_t          req,
  input  logic [WORD_W-1:0] opa,
  input  logic [WORD_W-1:0] opb,
  output alu_stat_t         stat,
  output logic [WORD_W-1:0] result
);
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [1:0]        fn_r, fn_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_sh;

  assign rem_sh = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_comb begin
    res_nxt  = res_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    fn_nxt   = fn_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      fn_nxt = req.fn;
      unique case (req.fn)
        FN_ADD: begin
          res_nxt  = opa + opb;
          done_nxt = 1'b1;
        end
        FN_SUB: begin
          res_nxt  = opa - opb;
          done_nxt = 1'b1;
        end
        FN_MUL: begin
          busy_nxt = 1'b1;
          cnt_nxt  = '0;
        end
        default: begin
          busy_nxt = 1'b1;
          quo_nxt  = opa;
          rem_nxt  = '0;
          dvs_nxt  = opb;
          cnt_nxt  = 6'(WORD_W);
        end
      endcase
    end else if (busy_r) begin
      if (fn_r == FN_MUL) begin
        res_nxt  = prod_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // one quotient bit per cycle
        if (!trial[WORD_W]) begin
          rem_nxt = trial[WORD_W-1:0];
          quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          res_nxt  = quo_nxt;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    res_r  <= res_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    cnt_r  <= cnt_nxt;
    fn_r   <= fn_nxt;
    prod_r <= WORD_W'(opa * opb);
  end

  assign stat.done = done_r;
  assign result    = res_r;
endmodule

>>> sv/stored_program_cpu_core.sv
// top level of the stored-program processor core
//
//  channel | dir | handshake     | payload
//  in      | in  | valid / ready | operation, host_address, write_data
//  out     | out | valid / ready | read_data, pc_value, fetched_word, is_running,
//          |     |               | stop_cause, bounds_error
//  cfg     | in  | we            | cycle_limit
//
// one word at a time, taken only in S_IDLE: host write, start, register read and a refused
// step go straight to S_OUT, memory read through S_MEMRD, an executed step through S_MEMRD
// (registered fetch) and S_DEC, load also S_LDWB, add, sub, mul and div also S_ALU through the alu
// reset is synchronous; memory contents are not cleared
// a finished result waits in the output register while the next word is taken;
// that word then waits in S_OUT until the output register is free
`timescale 1ns / 1ps
module stored_program_cpu_core
  import spcc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned NUM_REGS  = NUM_REGS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  spcc_in_if.sink            in_ch,
  spcc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);
  localparam int unsigned MA_W = $clog2(MEM_WORDS);
  localparam int unsigned RI_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MEMRD = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_ALU   = 3'd3;
  localparam logic [2:0] S_LDWB  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] mem_q_r;
  logic              mem_re;
  logic [MA_W-1:0]   mem_ra;
  logic              mem_we;
  logic [MA_W-1:0]   mem_wa;
  logic [WORD_W-1:0] mem_wd;

  logic [WORD_W-1:0] regs_r [NUM_REGS];
  logic              rf_we;
  logic [3:0]        rf_wa;
  logic [WORD_W-1:0] rf_wd;

  logic [WORD_W-1:0]  pc_r, pc_nxt;
  logic [WORD_W-1:0]  ir_r, ir_nxt;
  logic               run_r, run_nxt;
  logic [LIMIT_W-1:0] steps_r, steps_nxt;
  logic [2:0]         cause_r, cause_nxt;
  logic [LIMIT_W-1:0] limit_r;

  logic [2:0]        hop_r, hop_nxt;
  logic              fetch_oob_r, fetch_oob_nxt;
  logic              oob_r, oob_nxt;
  logic [WORD_W-1:0] rdata_r, rdata_nxt;
  logic [3:0]        ld_ra_r, ld_ra_nxt;
  logic              ld_zero_r, ld_zero_nxt;
  logic              ovalid_r, ovalid_nxt;

  alu_req_t          areq;
  alu_stat_t         astat;
  logic [WORD_W-1:0] ares;

  logic [WORD_W-1:0] ra_v, rb_v, rc_v, daddr;
  logic [7:0]        opc;
  logic [3:0]        ra_i;

  function automatic logic [WORD_W-1:0] rd(input logic [3:0] idx,
                                           input logic [WORD_W-1:0] v);
    return (32'(idx) < NUM_REGS) ? v : '0;
  endfunction

  assign opc  = ir_r[31:24];
  assign ra_i = ir_r[23:20];
  assign ra_v = rd(ir_r[23:20], regs_r[ir_r[20 +: RI_W]]);
  assign rb_v = rd(ir_r[19:16], regs_r[ir_r[16 +: RI_W]]);
  assign rc_v = rd(ir_r[15:12], regs_r[ir_r[12 +: RI_W]]);
  assign daddr = rb_v + {16'd0, ir_r[15:0]};

  spcc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (areq),
    .opa    (rb_v),
    .opb    (rc_v),
    .stat   (astat),
    .result (ares)
  );

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    ir_nxt        = ir_r;
    run_nxt       = run_r;
    steps_nxt     = steps_r;
    cause_nxt     = cause_r;
    hop_nxt       = hop_r;
    fetch_oob_nxt = fetch_oob_r;
    oob_nxt       = oob_r;
    rdata_nxt     = rdata_r;
    ld_ra_nxt     = ld_ra_r;
    ld_zero_nxt   = ld_zero_r;
    ovalid_nxt    = ovalid_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    rf_we         = 1'b0;
    rf_wa         = '0;
    rf_wd         = '0;
    areq          = '0;
    if (out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          hop_nxt   = in_ch.operation;
          oob_nxt   = 1'b0;
          rdata_nxt = '0;
          state_nxt = S_OUT;
          case (in_ch.operation)
            HOP_WRITE: begin
              if (32'(in_ch.host_address) < MEM_WORDS) begin
                mem_we = 1'b1;
                mem_wa = MA_W'(in_ch.host_address);
                mem_wd = in_ch.write_data;
              end else begin
                oob_nxt = 1'b1;
              end
            end
            HOP_READ: begin
              if (32'(in_ch.host_address) < MEM_WORDS) begin
                mem_re    = 1'b1;
                mem_ra    = MA_W'(in_ch.host_address);
                state_nxt = S_MEMRD;
              end else begin
                oob_nxt = 1'b1;
              end
            end
            HOP_START: begin
              run_nxt   = 1'b1;
              pc_nxt    = '0;
              steps_nxt = '0;
              cause_nxt = CAUSE_NONE;
            end
            HOP_STEP: begin
              if (run_r) begin
                if (steps_r >= limit_r) begin
                  run_nxt   = 1'b0;
                  cause_nxt = CAUSE_LIMIT;
                end else begin
                  steps_nxt     = steps_r + 1'b1;
                  fetch_oob_nxt = !(pc_r < MEM_WORDS);
                  mem_re        = 1'b1;
                  mem_ra        = MA_W'(pc_r);
                  pc_nxt        = pc_r + 1'b1;
                  state_nxt     = S_MEMRD;
                end
              end
            end
            HOP_REG: begin
              rdata_nxt = rd(in_ch.host_address[3:0],
                             regs_r[in_ch.host_address[RI_W-1:0]]);
            end
            default: ;
          endcase
        end
      end
      S_MEMRD: begin
        if (hop_r == HOP_READ) begin
          rdata_nxt = mem_q_r;
          state_nxt = S_OUT;
        end else begin
          ir_nxt    = fetch_oob_r ? '0 : mem_q_r;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        case (opc)
          OP_NOP: ;
          OP_LOAD: begin
            ld_ra_nxt = ra_i;
            if (daddr < MEM_WORDS) begin
              mem_re      = 1'b1;
              mem_ra      = MA_W'(daddr);
              ld_zero_nxt = 1'b0;
            end else begin
              ld_zero_nxt = 1'b1;
              oob_nxt     = 1'b1;
            end
            state_nxt = S_LDWB;
          end
          OP_ST: begin
            if (daddr < MEM_WORDS) begin
              mem_we = 1'b1;
              mem_wa = MA_W'(daddr);
              mem_wd = ra_v;
            end else begin
              oob_nxt = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            areq.start = 1'b1;
            areq.fn    = (opc == OP_ADD) ? FN_ADD : (opc == OP_SUB) ? FN_SUB : FN_MUL;
            state_nxt  = S_ALU;
          end
          OP_DIV: begin
            if (rc_v == '0) begin
              run_nxt   = 1'b0;
              cause_nxt = CAUSE_DIV0;
            end else begin
              areq.start = 1'b1;
              areq.fn    = FN_DIV;
              state_nxt  = S_ALU;
            end
          end
          OP_JMP: pc_nxt = {16'd0, ir_r[15:0]};
          OP_JEQ: if (ra_v == rb_v) pc_nxt = {16'd0, ir_r[15:0]};
          OP_JNE: if (ra_v != rb_v) pc_nxt = {16'd0, ir_r[15:0]};
          OP_HALT: begin
            run_nxt   = 1'b0;
            cause_nxt = CAUSE_HALT;
          end
          default: begin
            run_nxt   = 1'b0;
            cause_nxt = CAUSE_BADOP;
          end
        endcase
      end
      S_ALU: begin
        if (astat.done) begin
          rf_we     = 1'b1;
          rf_wa     = ra_i;
          rf_wd     = ares;
          state_nxt = S_OUT;
        end
      end
      S_LDWB: begin
        rf_we     = 1'b1;
        rf_wa     = ld_ra_r;
        rf_wd     = ld_zero_r ? '0 : mem_q_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to be free
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (rf_we && (32'(rf_wa) < NUM_REGS)) begin
      regs_r[rf_wa[RI_W-1:0]] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      ir_r     <= '0;
      run_r    <= 1'b0;
      steps_r  <= '0;
      cause_r  <= CAUSE_NONE;
      limit_r  <= LIMIT_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      ir_r     <= ir_nxt;
      run_r    <= run_nxt;
      steps_r  <= steps_nxt;
      cause_r  <= cause_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
    hop_r       <= hop_nxt;
    fetch_oob_r <= fetch_oob_nxt;
    oob_r       <= oob_nxt;
    rdata_r     <= rdata_nxt;
    ld_ra_r     <= ld_ra_nxt;
    ld_zero_r   <= ld_zero_nxt;
  end

  // result word is captured when the state machine leaves S_OUT
  logic [WORD_W-1:0] o_rdata_r, o_pc_r, o_ir_r;
  logic              o_run_r, o_oob_r;
  logic [2:0]        o_cause_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && state_nxt == S_IDLE) begin
      o_rdata_r <= rdata_r;
      o_pc_r    <= pc_r;
      o_ir_r    <= ir_r;
      o_run_r   <= run_r;
      o_cause_r <= cause_r;
      o_oob_r   <= oob_r;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.read_data    = o_rdata_r;
  assign out_ch.pc_value     = o_pc_r;
  assign out_ch.fetched_word = o_ir_r;
  assign out_ch.is_running   = o_run_r;
  assign out_ch.stop_cause   = o_cause_r;
  assign out_ch.bounds_error = o_oob_r;
endmodule

>>> sv/spcc_checker.sv
// port-level checks for the processor core, bound to the top level
`timescale 1ns / 1ps
module spcc_checker
  import spcc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_running,
  input logic [2:0] stop_cause
);
  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a running core reports no stop cause
  a_run_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_running |-> stop_cause == CAUSE_NONE)
    else $error("running with a stop cause");

  // no word is taken right after one was accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");

  // stop cause stays in its range
  a_cause_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> stop_cause <= CAUSE_LIMIT)
    else $error("stop cause out of range");
endmodule

bind stored_program_cpu_core spcc_checker u_spcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .is_running (out_ch.is_running),
  .stop_cause (out_ch.stop_cause)
);

>>> tb/tb.sv
// testbench for the stored-program processor core: directed programs and random host traffic
`timescale 1ns / 1ps
module tb;
  import spcc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  spcc_in_if in_ch ();
  spcc_out_if out_ch ();

  stored_program_cpu_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pc_value;
    logic [31:0] fetched_word;
    logic        is_running;
    logic [2:0]  stop_cause;
    logic        bounds_error;
  } core_out_t;

  // predictor state
  logic [31:0] mem_m [MEM_WORDS_DEF];
  bit          mem_written [MEM_WORDS_DEF];
  logic [31:0] regs_m [NUM_REGS_DEF];
  logic [31:0] pc_m, ir_m;
  logic        run_m;
  logic [15:0] steps_m;
  logic [2:0]  cause_m;
  logic [15:0] limit_m;

  core_out_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;

  function automatic logic do_step_model();
    logic [31:0] w, addr;
    logic [7:0] op;
    logic [3:0] ra, rb, rc;
    logic [15:0] imm;
    logic oob;
    oob = 1'b0;
    if (!run_m) return 1'b0;
    if (steps_m >= limit_m) begin
      run_m = 1'b0; cause_m = CAUSE_LIMIT; return 1'b0;
    end
    steps_m = steps_m + 16'd1;
    w = (pc_m < MEM_WORDS_DEF) ? mem_m[pc_m] : 32'd0;
    ir_m = w;
    pc_m = pc_m + 32'd1;
    op = w[31:24]; ra = w[23:20]; rb = w[19:16]; rc = w[15:12]; imm = w[15:0];
    addr = regs_m[rb] + {16'd0, imm};
    case (op)
      OP_NOP: ;
      OP_LOAD: begin
        if (addr < MEM_WORDS_DEF) regs_m[ra] = mem_m[addr];
        else begin regs_m[ra] = 32'd0; oob = 1'b1; end
      end
      OP_ST: begin
        if (addr < MEM_WORDS_DEF) begin
          mem_m[addr] = regs_m[ra]; mem_written[addr] = 1'b1;
        end else oob = 1'b1;
      end
      OP_ADD: regs_m[ra] = regs_m[rb] + regs_m[rc];
      OP_SUB: regs_m[ra] = regs_m[rb] - regs_m[rc];
      OP_MUL: regs_m[ra] = regs_m[rb] * regs_m[rc];
      OP_DIV: begin
        if (regs_m[rc] != 32'd0) regs_m[ra] = regs_m[rb] / regs_m[rc];
        else begin run_m = 1'b0; cause_m = CAUSE_DIV0; end
      end
      OP_JMP: pc_m = {16'd0, imm};
      OP_JEQ: if (regs_m[ra] == regs_m[rb]) pc_m = {16'd0, imm};
      OP_JNE: if (regs_m[ra] != regs_m[rb]) pc_m = {16'd0, imm};
      OP_HALT: begin run_m = 1'b0; cause_m = CAUSE_HALT; end
      default: begin run_m = 1'b0; cause_m = CAUSE_BADOP; end
    endcase
    return oob;
  endfunction

  // true when the next step would fetch or load a word never written
  function automatic bit step_reads_unwritten();
    logic [31:0] w, addr;
    if (!run_m || steps_m >= limit_m) return 1'b0;
    if (pc_m >= MEM_WORDS_DEF) return 1'b0;
    if (!mem_written[pc_m]) return 1'b1;
    w = mem_m[pc_m];
    addr = regs_m[w[19:16]] + {16'd0, w[15:0]};
    return (w[31:24] == OP_LOAD) && (addr < MEM_WORDS_DEF) && !mem_written[addr];
  endfunction

  function automatic core_out_t predict_core(logic [2:0] op, logic [11:0] ha, logic [31:0] wd);
    core_out_t r;
    r = '0;
    case (op)
      HOP_WRITE: begin mem_m[ha] = wd; mem_written[ha] = 1'b1; end
      HOP_READ: r.read_data = mem_m[ha];
      HOP_START: begin run_m = 1'b1; pc_m = 0; steps_m = 0; cause_m = CAUSE_NONE; end
      HOP_STEP: r.bounds_error = do_step_model();
      HOP_REG: r.read_data = regs_m[ha[3:0]];
      default: ;
    endcase
    r.pc_value = pc_m; r.fetched_word = ir_m;
    r.is_running = run_m; r.stop_cause = cause_m;
    return r;
  endfunction

  task automatic send_word(logic [2:0] op, logic [11:0] ha, logic [31:0] wd);
    while (idle_on && $urandom_range(99) < 30) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.operation = op; in_ch.host_address = ha; in_ch.write_data = wd;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(predict_core(op, ha, wd));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    wait_drain();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_m = v;
  endtask

  // result checker
  always @(posedge clk) begin
    core_out_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_ch.read_data !== e.read_data) begin
          $error("read_data exp %h got %h", e.read_data, out_ch.read_data); errors++;
        end
        if (out_ch.pc_value !== e.pc_value) begin
          $error("pc_value exp %h got %h", e.pc_value, out_ch.pc_value); errors++;
        end
        if (out_ch.fetched_word !== e.fetched_word) begin
          $error("fetched_word exp %h got %h", e.fetched_word, out_ch.fetched_word); errors++;
        end
        if (out_ch.is_running !== e.is_running) begin
          $error("is_running exp %b got %b", e.is_running, out_ch.is_running); errors++;
        end
        if (out_ch.stop_cause !== e.stop_cause) begin
          $error("stop_cause exp %0d got %0d", e.stop_cause, out_ch.stop_cause); errors++;
        end
        if (out_ch.bounds_error !== e.bounds_error) begin
          $error("bounds_error exp %b got %b", e.bounds_error, out_ch.bounds_error); errors++;
        end
      end
    end
  end

  // receiver stalls
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(idle_on && $urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] insn(logic [7:0] op, logic [3:0] ra, logic [3:0] rb,
                                       logic [15:0] imm);
    return {op, ra, rb, imm};
  endfunction

  // program in words 0..: constants then arithmetic, jumps and halt
  task automatic test_directed();
    send_word(HOP_WRITE, 12'd4095, 32'hFFFF_FFFF);
    send_word(HOP_READ, 12'd4095, 0);
    send_word(HOP_WRITE, 12'd100, 32'd7);
    send_word(HOP_WRITE, 12'd101, 32'd0);
    send_word(HOP_WRITE, 12'd0, insn(OP_LOAD, 4'd1, 4'd0, 16'd100));
    send_word(HOP_WRITE, 12'd1, insn(OP_LOAD, 4'd2, 4'd0, 16'd4095));
    send_word(HOP_WRITE, 12'd2, insn(OP_ADD, 4'd3, 4'd1, {4'd2, 12'd0}));
    send_word(HOP_WRITE, 12'd3, insn(OP_SUB, 4'd4, 4'd1, {4'd2, 12'd0}));
    send_word(HOP_WRITE, 12'd4, insn(OP_MUL, 4'd5, 4'd2, {4'd2, 12'd0}));
    send_word(HOP_WRITE, 12'd5, insn(OP_DIV, 4'd6, 4'd2, {4'd1, 12'd0}));
    send_word(HOP_WRITE, 12'd6, insn(OP_ST, 4'd6, 4'd0, 16'd102));
    send_word(HOP_WRITE, 12'd7, insn(OP_LOAD, 4'd7, 4'd2, 16'd10));
    send_word(HOP_WRITE, 12'd8, insn(OP_ST, 4'd7, 4'd1, 16'hFFFF));
    send_word(HOP_WRITE, 12'd9, insn(OP_JEQ, 4'd1, 4'd2, 16'd0));
    send_word(HOP_WRITE, 12'd10, insn(OP_JNE, 4'd1, 4'd2, 16'd12));
    send_word(HOP_WRITE, 12'd12, insn(OP_JMP, 4'd0, 4'd0, 16'd13));
    send_word(HOP_WRITE, 12'd13, insn(OP_HALT, 4'd0, 4'd0, 16'd0));
    send_word(HOP_START, 0, 0);
    repeat (13) send_word(HOP_STEP, 0, 0);
    send_word(HOP_STEP, 0, 0);
    for (int i = 0; i < 16; i++) send_word(HOP_REG, 12'(i + 16 * i), 0);
    send_word(HOP_READ, 12'd102, 0);
    send_word(3'd5, 0, 0); send_word(3'd7, 0, 0);
  endtask

  task automatic test_faults();
    send_word(HOP_WRITE, 12'd20, insn(OP_DIV, 4'd1, 4'd1, {4'd15, 12'd0}));
    send_word(HOP_WRITE, 12'd21, insn(8'hFF, 4'd0, 4'd0, 16'd0));
    send_word(HOP_WRITE, 12'd0, insn(OP_JMP, 4'd0, 4'd0, 16'd20));
    send_word(HOP_REG, 12'd15, 0);
    send_word(HOP_START, 0, 0);
    repeat (3) send_word(HOP_STEP, 0, 0);
    send_word(HOP_WRITE, 12'd0, insn(OP_JMP, 4'd0, 4'd0, 16'd21));
    send_word(HOP_START, 0, 0);
    repeat (3) send_word(HOP_STEP, 0, 0);
    // jump past memory: fetches read as nop
    send_word(HOP_WRITE, 12'd0, insn(OP_JMP, 4'd0, 4'd0, 16'hFFFF));
    send_word(HOP_START, 0, 0);
    repeat (3) send_word(HOP_STEP, 0, 0);
  endtask

  task automatic test_limit();
    send_word(HOP_WRITE, 12'd0, insn(OP_JMP, 4'd0, 4'd0, 16'd0));
    set_limit(16'd1);
    send_word(HOP_START, 0, 0);
    repeat (3) send_word(HOP_STEP, 0, 0);
    set_limit(16'd0);
    send_word(HOP_START, 0, 0);
    send_word(HOP_STEP, 0, 0);
    set_limit(16'd5);
    send_word(HOP_START, 0, 0);
    repeat (7) send_word(HOP_STEP, 0, 0);
  endtask

  function automatic logic [31:0] rand_insn();
    logic [7:0] op;
    logic [15:0] imm;
    int k;
    k = $urandom_range(99);
    if (k < 3) op = 8'($urandom_range(255, 11));
    else if (k < 5) op = OP_DIV;
    else if (k < 7) op = OP_HALT;
    else op = 8'($urandom_range(9));
    imm = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(31));
    if (op == OP_LOAD) imm = 16'($urandom_range(39, 32)) | (($urandom_range(19) == 0) ? 16'hF000 : 0);
    if (op == OP_ST) imm = 16'($urandom_range(47, 32)) | (($urandom_range(19) == 0) ? 16'hF000 : 0);
    return {op, 4'($urandom), 4'($urandom), imm};
  endfunction

  // random programs in words 0..31, data 32..47 initialized, random steps
  task automatic test_random(int n_words);
    int sent;
    logic [11:0] a;
    sent = 0;
    while (sent < n_words) begin
      for (int i = 0; i < 48; i++) begin
        send_word(HOP_WRITE, 12'(i), (i < 32) ? rand_insn() : $urandom);
        sent++;
      end
      // high addresses, guarded by write-before-read
      a = 12'($urandom_range(4095, 48));
      send_word(HOP_WRITE, a, $urandom); send_word(HOP_READ, a, 0);
      send_word(HOP_START, 0, 0);
      repeat ($urandom_range(40, 5)) begin
        case ($urandom_range(9))
          0: send_word(HOP_REG, 12'($urandom), 0);
          1: send_word(HOP_READ, 12'($urandom_range(47)), 0);
          2: send_word(3'($urandom_range(7, 5)), 12'($urandom), $urandom);
          default: begin
            // restart rather than touch a word never written
            if (step_reads_unwritten()) send_word(HOP_START, 0, 0);
            else send_word(HOP_STEP, 0, 0);
          end
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0; in_ch.host_address = '0; in_ch.write_data = '0;
    regs_m = '{default: '0};
    mem_m = '{default: '0};
    pc_m = 0; ir_m = 0; run_m = 0; steps_m = 0; cause_m = CAUSE_NONE;
    limit_m = LIMIT_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_faults();
    test_limit();
    set_limit(16'hFFFF);
    // hold the receiver off while words keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_word(HOP_REG, 12'($urandom), 0);
    join
    test_random(250);
    set_limit(16'd12);
    idle_on = 1'b0;
    test_random(200);
    idle_on = 1'b1;
    set_limit(LIMIT_RESET);
    test_random(250);
    wait_drain();
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

>>> filelist.f
sv/spcc_pkg.sv
sv/spcc_if.sv
sv/spcc_alu.sv
sv/stored_program_cpu_core.sv
sv/spcc_checker.sv
tb/tb.sv
